/* rtl/fct_pkg.sv */
// flow context table: shared types and constants
// used by fct_ctrl, fct_dp and flow_context_table_top
package fct_pkg;

  localparam logic [31:0] KEY_FREE = 32'hFFFF_FFFF;

  localparam logic [1:0] KIND_LOOKUP = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  localparam logic [2:0] ST_HIT      = 3'd0;
  localparam logic [2:0] ST_MISS     = 3'd1;
  localparam logic [2:0] ST_PRESENT  = 3'd2;
  localparam logic [2:0] ST_INSERTED = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;
  localparam logic [2:0] ST_REMOVED  = 3'd5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  // mode layout: bit0 acked, bit1 segmented, bit2 handover, bits 4:3 tx type
  typedef logic [4:0] mode_t;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } fct_cmd_t;

  typedef struct packed {
    logic last_issue;
  } fct_stat_t;

endpackage

/* rtl/fct_ctrl.sv */
// flow context table: scan controller state machine
// depends on fct_pkg; drives fct_dp through fct_cmd_t
module fct_ctrl
  import fct_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  fct_stat_t stat,
  output fct_cmd_t  cmd,
  output logic      busy
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.last_issue) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    case (state)
      S_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      S_SCAN: begin
        cmd.issue = 1'b1;
      end
      S_DRAIN: begin
        cmd = '0;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  a_load_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> state == S_SCAN)
    else $error("accepted word did not start a scan");

  a_scan_drain: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && stat.last_issue) |=> state == S_DRAIN)
    else $error("scan did not end after last entry");

  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |=> state == S_DONE)
    else $error("drain not followed by finish");

endmodule

/* rtl/fct_dp.sv */
// flow context table: key/mode memory, valid bits, scan compare and result
// depends on fct_pkg; commanded by fct_ctrl
module fct_dp
  import fct_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
)(
  input  logic        clk,
  input  logic        rst,
  input  fct_cmd_t    cmd,
  output fct_stat_t   stat,
  input  logic [1:0]  kind,
  input  logic [31:0] flow_id,
  input  logic [31:0] dest_id,
  input  logic        acked_mode,
  input  logic        fraged_mode,
  input  logic        handover_flag,
  input  logic [1:0]  tx_type,
  output logic        done,
  output logic [2:0]  status,
  output logic [3:0]  slot_index,
  output logic        entry_acked,
  output logic        entry_fraged,
  output logic        entry_handover,
  output logic [1:0]  entry_tx_type,
  output logic        ordered_path,
  output logic [4:0]  removed_count
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [31:0] flow_mem [TABLE_ENTRIES];
  logic [31:0] dest_mem [TABLE_ENTRIES];
  mode_t       mode_mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] vld;

  logic [1:0]  req_kind;
  logic [31:0] req_flow;
  logic [31:0] req_dest;
  mode_t       req_mode;

  logic [IDX_W-1:0] rd_idx;
  logic             ev_en;
  logic [IDX_W-1:0] ev_idx;
  logic             ev_vld;
  logic [31:0]      ev_flow_raw;
  logic [31:0]      ev_dest_raw;
  mode_t            ev_mode_raw;

  logic             found;
  logic [IDX_W-1:0] match_idx;
  mode_t            match_mode;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic [CNT_W-1:0] rm_count;

  logic [31:0] e_flow;
  logic [31:0] e_dest;
  mode_t       e_mode;
  logic        e_hit;
  logic        e_free;
  logic        e_rm;
  logic        wr_en;

  logic [2:0]       res_status;
  logic [IDX_W-1:0] res_idx;
  mode_t            res_mode;
  logic             res_report;
  logic             res_ordered;
  logic [IDX_W+3:0] res_idx_ext;
  logic [CNT_W+4:0] rm_count_ext;

  assign stat.last_issue = (rd_idx == IDX_W'(TABLE_ENTRIES - 1));

  // unwritten entries read as free keys and zero mode
  assign e_flow = ev_vld ? ev_flow_raw : KEY_FREE;
  assign e_dest = ev_vld ? ev_dest_raw : KEY_FREE;
  assign e_mode = ev_vld ? ev_mode_raw : '0;
  assign e_hit  = (e_flow == req_flow) && (e_dest == req_dest);
  assign e_free = (e_flow == KEY_FREE);
  assign e_rm   = (e_dest == req_dest) && ((req_flow == KEY_FREE) || (e_flow == req_flow));

  assign wr_en = cmd.finish && (req_kind == KIND_STORE) && !found && free_found;

  // memory: one read per scan cycle, one write at commit
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      ev_flow_raw <= flow_mem[rd_idx];
      ev_dest_raw <= dest_mem[rd_idx];
      ev_mode_raw <= mode_mem[rd_idx];
    end
    if (wr_en) begin
      flow_mem[free_idx] <= req_flow;
      dest_mem[free_idx] <= req_dest;
      mode_mem[free_idx] <= req_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      ev_en <= 1'b0;
    end else begin
      ev_en <= cmd.issue;
      if (ev_en && req_kind == KIND_REMOVE && e_rm) begin
        vld[ev_idx] <= 1'b0;
      end
      if (wr_en) begin
        vld[free_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      ev_idx <= rd_idx;
      ev_vld <= vld[rd_idx];
      rd_idx <= rd_idx + IDX_W'(1);
    end
    if (cmd.load) begin
      req_kind   <= kind;
      req_flow   <= flow_id;
      req_dest   <= dest_id;
      req_mode   <= {tx_type, handover_flag, fraged_mode, acked_mode};
      rd_idx     <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
      rm_count   <= '0;
    end else if (ev_en) begin
      if (e_hit && !found) begin
        found      <= 1'b1;
        match_idx  <= ev_idx;
        match_mode <= e_mode;
      end
      if (e_free && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= ev_idx;
      end
      if (req_kind == KIND_REMOVE && e_rm && !e_free) begin
        rm_count <= rm_count + CNT_W'(1);
      end
    end
  end

  always_comb begin
    res_status  = ST_MISS;
    res_idx     = match_idx;
    res_mode    = match_mode;
    res_report  = 1'b0;
    res_ordered = 1'b0;
    case (req_kind)
      KIND_STORE: begin
        if (found) begin
          res_status = ST_PRESENT;
          res_report = 1'b1;
        end else if (free_found) begin
          res_status = ST_INSERTED;
          res_idx    = free_idx;
          res_mode   = req_mode;
          res_report = 1'b1;
        end else begin
          res_status = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        res_status = ST_REMOVED;
      end
      default: begin
        if (found) begin
          res_status  = ST_HIT;
          res_report  = 1'b1;
          res_ordered = match_mode[0] | match_mode[1];
        end
      end
    endcase
  end

  assign res_idx_ext  = {4'b0000, res_idx};
  assign rm_count_ext = {5'b00000, rm_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status         <= res_status;
      slot_index     <= res_report ? res_idx_ext[3:0] : 4'd0;
      entry_acked    <= res_report & res_mode[0];
      entry_fraged   <= res_report & res_mode[1];
      entry_handover <= res_report & res_mode[2];
      entry_tx_type  <= res_report ? res_mode[4:3] : 2'd0;
      ordered_path   <= res_ordered;
      removed_count  <= (req_kind == KIND_REMOVE) ? rm_count_ext[4:0] : 5'd0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ev_en |-> rm_count <= CNT_W'(TABLE_ENTRIES))
    else $error("remove count beyond table size");

  a_finish_done: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> done)
    else $error("finished word not strobed");

  a_insert_valid: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> vld[$past(free_idx)])
    else $error("inserted entry not marked valid");

endmodule

/* rtl/flow_context_table_top.sv */
// flow context table: top level joining controller and datapath
// depends on fct_pkg, fct_ctrl, fct_dp
//
// A word is taken at a clock edge with start high and busy low. Each word
// scans the whole table, one memory read per cycle, before its result
// appears; done is high for a single cycle with the result, which cannot be
// held off, so capture it when done is high. The result stays on the output
// ports until the next result replaces it. Busy falls in the same cycle that
// done rises, so the next word may be started while the previous result is
// shown; a new word is not taken while one is still being scanned. Reset
// marks every entry free at once; no clearing pass is needed.
module flow_context_table_top
  import fct_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [31:0] flow_id,
  input  logic [31:0] dest_id,
  input  logic        acked_mode,
  input  logic        fraged_mode,
  input  logic        handover_flag,
  input  logic [1:0]  tx_type,
  output logic        done,
  output logic [2:0]  status,
  output logic [3:0]  slot_index,
  output logic        entry_acked,
  output logic        entry_fraged,
  output logic        entry_handover,
  output logic [1:0]  entry_tx_type,
  output logic        ordered_path,
  output logic [4:0]  removed_count
);

  fct_cmd_t  cmd;
  fct_stat_t stat;

  fct_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  fct_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .kind           (kind),
    .flow_id        (flow_id),
    .dest_id        (dest_id),
    .acked_mode     (acked_mode),
    .fraged_mode    (fraged_mode),
    .handover_flag  (handover_flag),
    .tx_type        (tx_type),
    .done           (done),
    .status         (status),
    .slot_index     (slot_index),
    .entry_acked    (entry_acked),
    .entry_fraged   (entry_fraged),
    .entry_handover (entry_handover),
    .entry_tx_type  (entry_tx_type),
    .ordered_path   (ordered_path),
    .removed_count  (removed_count)
  );

endmodule

/* verif/fct_answer_checker.sv */
`timescale 1ns / 1ps
// flow context table checker: keeps its own copy of the table, predicts the
// answer to every accepted word and compares it with the answer shown on done
// depends on fct_pkg
module fct_answer_checker
  import fct_pkg::*;
#(
  parameter int TABLE_ENTRIES = 16
)(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  kind,
  input  logic [31:0] flow_id,
  input  logic [31:0] dest_id,
  input  logic        acked_mode,
  input  logic        fraged_mode,
  input  logic        handover_flag,
  input  logic [1:0]  tx_type,
  input  logic        done,
  input  logic [2:0]  status,
  input  logic [3:0]  slot_index,
  input  logic        entry_acked,
  input  logic        entry_fraged,
  input  logic        entry_handover,
  input  logic [1:0]  entry_tx_type,
  input  logic        ordered_path,
  input  logic [4:0]  removed_count,
  output int          errors,
  output int          pending,
  output int          words_checked,
  output logic [5:0]  codes_seen
);

  typedef struct packed {
    logic [2:0] code;
    logic [3:0] slot;
    logic       acked;
    logic       fraged;
    logic       handover;
    logic [1:0] txt;
    logic       ordered;
    logic [4:0] cleared;
  } flow_answer_t;

  logic [31:0]  flow_tbl [TABLE_ENTRIES];
  logic [31:0]  dest_tbl [TABLE_ENTRIES];
  mode_t        mode_tbl [TABLE_ENTRIES];
  flow_answer_t answer_q [$];
  flow_answer_t want;
  int           fail_tally;
  int           checked_tally;
  logic [5:0]   seen_mask;

  function automatic flow_answer_t entry_view(input int idx, input logic [2:0] code);
    flow_answer_t a;
    a = '0;
    a.code     = code;
    a.slot     = idx[3:0];
    a.acked    = mode_tbl[idx][0];
    a.fraged   = mode_tbl[idx][1];
    a.handover = mode_tbl[idx][2];
    a.txt      = mode_tbl[idx][4:3];
    return a;
  endfunction

  task automatic resolve_request(input logic [1:0] k, input logic [31:0] f,
                                 input logic [31:0] d, input mode_t m,
                                 output flow_answer_t ans);
    int   match_at;
    int   free_at;
    int   cnt;
    logic every_flow;
    ans = '0;
    match_at = -1;
    free_at = -1;
    cnt = 0;
    every_flow = (f == KEY_FREE);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (match_at < 0 && flow_tbl[i] == f && dest_tbl[i] == d) match_at = i;
      if (free_at < 0 && flow_tbl[i] == KEY_FREE) free_at = i;
    end
    case (k)
      KIND_STORE: begin
        if (match_at >= 0) begin
          ans = entry_view(match_at, ST_PRESENT);
        end else if (free_at >= 0) begin
          flow_tbl[free_at] = f;
          dest_tbl[free_at] = d;
          mode_tbl[free_at] = m;
          ans = entry_view(free_at, ST_INSERTED);
        end else begin
          ans.code = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (dest_tbl[i] == d && (every_flow || flow_tbl[i] == f)) begin
            if (flow_tbl[i] != KEY_FREE) cnt++;
            flow_tbl[i] = KEY_FREE;
            dest_tbl[i] = KEY_FREE;
            mode_tbl[i] = '0;
          end
        end
        ans.code    = ST_REMOVED;
        ans.cleared = cnt[4:0];
      end
      default: begin
        if (match_at < 0) begin
          ans.code = ST_MISS;
        end else begin
          ans = entry_view(match_at, ST_HIT);
          ans.ordered = |mode_tbl[match_at][1:0];
        end
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (want_v !== got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      fail_tally++;
    end
  endtask

  initial begin
    fail_tally = 0;
    checked_tally = 0;
    seen_mask = '0;
  end

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        flow_tbl[i] = KEY_FREE;
        dest_tbl[i] = KEY_FREE;
        mode_tbl[i] = '0;
      end
      answer_q.delete();
    end else begin
      if (done) begin
        if (answer_q.size() == 0) begin
          $error("answer shown with no word outstanding");
          fail_tally++;
        end else begin
          want = answer_q.pop_front();
          check_field("status", 32'(want.code), 32'(status));
          check_field("slot_index", 32'(want.slot), 32'(slot_index));
          check_field("entry_acked", 32'(want.acked), 32'(entry_acked));
          check_field("entry_fraged", 32'(want.fraged), 32'(entry_fraged));
          check_field("entry_handover", 32'(want.handover), 32'(entry_handover));
          check_field("entry_tx_type", 32'(want.txt), 32'(entry_tx_type));
          check_field("ordered_path", 32'(want.ordered), 32'(ordered_path));
          check_field("removed_count", 32'(want.cleared), 32'(removed_count));
          checked_tally++;
          if (want.code <= ST_REMOVED) seen_mask[want.code] = 1'b1;
        end
      end
      if (start && !busy) begin
        resolve_request(kind, flow_id, dest_id,
                        {tx_type, handover_flag, fraged_mode, acked_mode}, want);
        answer_q = {answer_q, want};
      end
    end
    errors        <= fail_tally;
    pending       <= answer_q.size();
    words_checked <= checked_tally;
    codes_seen    <= seen_mask;
  end

endmodule

/* verif/flow_context_table_top_tb.sv */
`timescale 1ns / 1ps
// flow context table testbench: drives directed and random request words
// into the block, with the answer checker instantiated beside it
// depends on fct_pkg, flow_context_table_top, fct_answer_checker
module flow_context_table_top_tb;
  import fct_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int WORDS_PER_PHASE = 283;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  kind = KIND_LOOKUP;
  logic [31:0] flow_id = '0;
  logic [31:0] dest_id = '0;
  logic        acked_mode = 1'b0;
  logic        fraged_mode = 1'b0;
  logic        handover_flag = 1'b0;
  logic [1:0]  tx_type = '0;
  logic        done;
  logic [2:0]  status;
  logic [3:0]  slot_index;
  logic        entry_acked;
  logic        entry_fraged;
  logic        entry_handover;
  logic [1:0]  entry_tx_type;
  logic        ordered_path;
  logic [4:0]  removed_count;
  int          errors;
  int          pending;
  int          words_checked;
  logic [5:0]  codes_seen;

  int          idle_pct;
  int          quiet_cycles = 0;
  logic [31:0] flow_pool [6];
  logic [31:0] dest_pool [3];

  flow_context_table_top #(.TABLE_ENTRIES(TABLE_ENTRIES)) DUT (.*);

  fct_answer_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) answer_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no progress for %0d cycles", STALL_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(input logic [1:0] k, input logic [31:0] f,
                           input logic [31:0] d, input logic a, input logic fr,
                           input logic h, input logic [1:0] t);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start         <= 1'b1;
    kind          <= k;
    flow_id       <= f;
    dest_id       <= d;
    acked_mode    <= a;
    fraged_mode   <= fr;
    handover_flag <= h;
    tx_type       <= t;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_flow();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return flow_pool[$urandom_range(0, 5)];
    if (r < 75) return KEY_FREE;
    if (r < 78) return '0;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_dest();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return dest_pool[$urandom_range(0, 2)];
    if (r < 84) return KEY_FREE;
    if (r < 86) return '0;
    return $urandom;
  endfunction

  initial begin
    int          roll;
    int          store_wt;
    logic [1:0]  k;
    logic [31:0] f;
    logic [31:0] d;
    logic [31:0] fill_dest;

    idle_pct = 11;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // free slots match the all-ones pair; an all-ones flow stored stays free
    send_word(KIND_LOOKUP, '0, '0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_word(KIND_LOOKUP, KEY_FREE, KEY_FREE, 1'b0, 1'b0, 1'b0, 2'd0);
    send_word(KIND_STORE, KEY_FREE, 32'h0000_1234, 1'b0, 1'b1, 1'b0, 2'd2);
    send_word(KIND_LOOKUP, KEY_FREE, 32'h0000_1234, 1'b0, 1'b0, 1'b0, 2'd0);
    send_word(KIND_STORE, '0, '0, 1'b1, 1'b0, 1'b1, 2'd3);
    send_word(KIND_STORE, '0, '0, 1'b0, 1'b1, 1'b0, 2'd0);
    send_word(KIND_SPARE, '0, '0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_word(KIND_REMOVE, KEY_FREE, '0, 1'b0, 1'b0, 1'b0, 2'd0);
    send_word(KIND_REMOVE, 32'd5, 32'd5, 1'b0, 1'b0, 1'b0, 2'd0);

    // fill the whole table under one destination, overflow it, then clear it
    fill_dest = 32'hA5A5_5A5A;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      f = {27'($urandom), 1'b0, 4'(i)};
      send_word(KIND_STORE, f, fill_dest, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                2'($urandom_range(0, 3)));
    end
    send_word(KIND_STORE, 32'hFFFF_FFFE, '0, 1'b1, 1'b1, 1'b1, 2'd3);
    send_word(KIND_REMOVE, KEY_FREE, fill_dest, 1'b0, 1'b0, 1'b0, 2'd0);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 11 : (phase == 1) ? 54 : 0;
      foreach (flow_pool[i]) flow_pool[i] = $urandom;
      foreach (dest_pool[i]) dest_pool[i] = $urandom;
      for (int n = 0; n < WORDS_PER_PHASE; n++) begin
        roll = $urandom_range(0, 99);
        store_wt = ((n / 40) % 2 == 1) ? 65 : 35;
        if (roll < store_wt) k = KIND_STORE;
        else if (roll < store_wt + 12) k = KIND_REMOVE;
        else if (roll < store_wt + 16) k = KIND_SPARE;
        else k = KIND_LOOKUP;
        f = pick_flow();
        d = pick_dest();
        if (k == KIND_REMOVE && $urandom_range(0, 3) == 0) f = KEY_FREE;
        send_word(k, f, d, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)));
      end
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (TABLE_ENTRIES + 4) @(posedge clk);

    $display("%0d answers compared over three sender idling profiles", words_checked);
    $display("answer codes reached (removed down to hit): %b", codes_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
